// ===== hw/rtl/fdli_pkg.sv =====
// Shared constants and types for the fractional delay line.
// Imported by every module of the block; no dependencies of its own.
package fdli_pkg;

  // Default store depth in samples
  localparam int DEPTH_DEF = 4096;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 28;
  localparam int FRAC_W   = 16;
  localparam int INT_W    = 12;

  // Delay register reset: 2048.0 samples
  localparam logic [DELAY_W-1:0] DELAY_RESET = 28'h800_0000;

  // Register port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_DELAY = 1'b0;  // register index, taken from paddr[2]

  // Reciprocal shift used to reduce the integer delay modulo the depth
  localparam int RECIP_SHIFT = 24;

  // Per-tap control carried from the address stage to the blend stage
  typedef struct packed {
    logic fwd0;    // tap 0 hits the entry written in the same cycle
    logic fwd1;    // tap 1 hits the entry written in the same cycle
    logic blank0;  // tap 0 entry never written since reset
    logic blank1;  // tap 1 entry never written since reset
  } tap_ctl_t;

endpackage

// ===== hw/rtl/fdli_ram.sv =====
// Sample store: one write port, two read ports, registered read data.
// Depends on fdli_pkg for the sample width.
module fdli_ram #(
  parameter int DEPTH = fdli_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fdli_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr0,
  input  logic [AW-1:0]                 raddr1,
  output logic [fdli_pkg::SAMPLE_W-1:0] rdata0,
  output logic [fdli_pkg::SAMPLE_W-1:0] rdata1
);
  import fdli_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata0_r;
  logic [SAMPLE_W-1:0] rdata1_r;

  // Write the new sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both taps; data returns the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== hw/rtl/fdli_cfg.sv =====
// Register port for the delay setting and reduction of its integer part modulo the depth.
// Depends on fdli_pkg for register layout and widths.
module fdli_cfg #(
  parameter int DEPTH = fdli_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fdli_pkg::PADDR_W-1:0] paddr,
  input  logic [fdli_pkg::PDATA_W-1:0] pwdata,
  output logic [fdli_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [AW-1:0]                ipart,
  output logic [fdli_pkg::FRAC_W-1:0]  frac,
  output logic                         busy
);
  import fdli_pkg::*;

  localparam int RECIP = (1 << RECIP_SHIFT) / DEPTH;
  localparam int QP_W  = RECIP_SHIFT + INT_W;
  localparam int RM_W  = INT_W + 1;

  logic [DELAY_W-1:0] delay_r;
  logic [INT_W-1:0]   quot_r;
  logic [INT_W-1:0]   quot_nxt;
  logic [AW-1:0]      ipart_r;
  logic [AW-1:0]      ipart_nxt;
  logic [1:0]         busy_r;
  logic [1:0]         busy_nxt;
  logic               wr_en;
  logic [INT_W-1:0]   int_raw;
  logic [QP_W-1:0]    quot_prod;
  logic [QP_W-1:0]    back_prod;
  logic [RM_W-1:0]    rem;
  logic [RM_W-1:0]    rem_fix;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (paddr[2] == REG_DELAY);
  assign int_raw = delay_r[DELAY_W-1:FRAC_W];

  // Read back the delay register; other addresses read zero
  always_comb begin
    if (paddr[2] == REG_DELAY) begin
      prdata = PDATA_W'(delay_r);
    end else begin
      prdata = '0;
    end
  end

  // Store the delay setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (wr_en) begin
      delay_r <= pwdata[DELAY_W-1:0];
    end
  end

  // Estimate the quotient by reciprocal multiply; may fall short by one
  always_comb begin
    quot_prod = QP_W'(int_raw) * QP_W'(RECIP);
    quot_nxt  = quot_prod[QP_W-1:RECIP_SHIFT];
  end

  // Form the remainder and correct the estimate with one subtract
  always_comb begin
    back_prod = QP_W'(quot_r) * QP_W'(DEPTH);
    rem       = {1'b0, int_raw} - back_prod[RM_W-1:0];
    if (32'(rem) >= DEPTH) begin
      rem_fix = rem - RM_W'(DEPTH);
    end else begin
      rem_fix = rem;
    end
    ipart_nxt = AW'(rem_fix);
  end

  always_ff @(posedge clk) begin
    quot_r  <= quot_nxt;
    ipart_r <= ipart_nxt;
  end

  // Hold off items until the reduced integer part has settled
  always_comb begin
    if (wr_en) begin
      busy_nxt = 2'd2;
    end else if (busy_r != 2'd0) begin
      busy_nxt = busy_r - 2'd1;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 2'd2;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign ipart = ipart_r;
  assign frac  = delay_r[FRAC_W-1:0];
  assign busy  = (busy_r != 2'd0);

endmodule

// ===== hw/rtl/fdli_interp.sv =====
// Blend stage: tap selection, difference multiply, rounding and output register.
// Depends on fdli_pkg for the tap control struct and widths.
module fdli_interp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  output logic                          s1_adv,
  input  fdli_pkg::tap_ctl_t            ctl,
  input  logic [fdli_pkg::SAMPLE_W-1:0] fwd_sample,
  input  logic [fdli_pkg::SAMPLE_W-1:0] rd0,
  input  logic [fdli_pkg::SAMPLE_W-1:0] rd1,
  input  logic [fdli_pkg::FRAC_W-1:0]   alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdli_pkg::SAMPLE_W-1:0] out_sample
);
  import fdli_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int ADJ_W  = PROD_W - FRAC_W;

  logic signed [SAMPLE_W-1:0] x0;
  logic signed [SAMPLE_W-1:0] x1;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] x0_r;
  logic                       v2_r;
  logic                       s2_adv;
  logic                       o_adv;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [ADJ_W-1:0]    adj;
  logic signed [ADJ_W-1:0]    sum;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_sample_r;

  // Stage enables: a stage loads when it is empty or its successor moves
  assign o_adv  = !out_valid_r || out_ready;
  assign s2_adv = !v2_r || o_adv;
  assign s1_adv = s2_adv;

  // Pick each tap: same-cycle write first, then unwritten entries read zero
  always_comb begin
    if (ctl.fwd0) begin
      x0 = fwd_sample;
    end else if (ctl.blank0) begin
      x0 = '0;
    end else begin
      x0 = rd0;
    end
    if (ctl.fwd1) begin
      x1 = fwd_sample;
    end else if (ctl.blank1) begin
      x1 = '0;
    end else begin
      x1 = rd1;
    end
    diff     = DIFF_W'(x1) - DIFF_W'(x0);
    prod_nxt = PROD_W'(diff) * $signed({1'b0, alpha});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_adv) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      prod_r <= prod_nxt;
      x0_r   <= x0;
    end
  end

  // Round the weighted difference to nearest and add it to the first tap
  always_comb begin
    rnd = prod_r + PROD_W'(32'sd32768);
    adj = rnd[PROD_W-1:FRAC_W];
    sum = ADJ_W'(x0_r) + adj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_adv) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      out_sample_r <= sum[SAMPLE_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// ===== hw/rtl/fractional_delay_line_linear_interp_unit.sv =====
// Fractional delay line with a linearly interpolated read tap, Q1.15 samples.
// Depends on fdli_pkg, fdli_ram, fdli_cfg and fdli_interp.
//
// The block takes one item per clock cycle unless out_ready holds the output or the
// delay is being reduced. A result is presented on out_valid once its item has been
// through the registers in order: the store read data and tap control are registered
// at the accepting edge, then the blend multiply, then the output register. Each
// item writes one entry and reads two, all in the same cycle on the store's write
// port and two read ports; a tap that lands on the entry being written takes the new
// sample directly. No clearing pass is needed after reset: a fill count marks
// entries not yet written, and these read as zero. After a write of the delay
// register, and after reset, the input stalls while the integer delay is reduced
// modulo the depth.
module fractional_delay_line_linear_interp_unit #(
  parameter int DEPTH = fdli_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_sample_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           out_sample_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fdli_pkg::PADDR_W-1:0] paddr,
  input  logic [fdli_pkg::PDATA_W-1:0] pwdata,
  output logic [fdli_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import fdli_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int START = DEPTH / 2;
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW-1:0] START_A = AW'(START);
  localparam logic [AW-1:0] WRAP_A  = AW'(DEPTH - START);
  localparam logic [CW-1:0] FULL    = CW'(DEPTH);

  logic [AW-1:0]       ipart;
  logic [FRAC_W-1:0]   frac;
  logic                cfg_busy;
  logic [AW-1:0]       wptr_r;
  logic [AW-1:0]       wptr_nxt;
  logic [CW-1:0]       fill_r;
  logic [CW-1:0]       fill_nxt;
  logic                in_fire;
  logic                s1_en;
  logic                s2_adv;
  logic [AW:0]         pos_sum;
  logic [AW:0]         pos;
  logic [AW-1:0]       raddr0;
  logic [AW-1:0]       raddr1;
  logic [AW-1:0]       off0;
  logic [AW-1:0]       off1;
  tap_ctl_t            ctl_nxt;
  tap_ctl_t            ctl_r;
  logic                v1_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [FRAC_W-1:0]   alpha_nxt;
  logic [FRAC_W-1:0]   alpha_r;
  logic [SAMPLE_W-1:0] rd0;
  logic [SAMPLE_W-1:0] rd1;
  logic [SAMPLE_W-1:0] out_bits;

  fdli_cfg #(.DEPTH(DEPTH), .AW(AW)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ipart   (ipart),
    .frac    (frac),
    .busy    (cfg_busy)
  );

  // Handshake: stage one loads when empty or when the blend stage moves
  assign s1_en    = !v1_r || s2_adv;
  assign in_ready = s1_en && !cfg_busy;
  assign in_fire  = in_valid && in_ready;

  // Tap address: write pointer minus delay, one further back for a nonzero fraction
  always_comb begin
    pos_sum = {1'b0, wptr_r} + DEPTH_X - {1'b0, ipart} - (AW + 1)'(frac != '0);
    if (pos_sum >= DEPTH_X) begin
      pos = pos_sum - DEPTH_X;
    end else begin
      pos = pos_sum;
    end
    raddr0 = pos[AW-1:0];
    if (raddr0 == LAST) begin
      raddr1 = '0;
    end else begin
      raddr1 = raddr0 + AW'(1);
    end
    alpha_nxt = FRAC_W'((FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(frac));
  end

  // Distance of each tap from the first entry written after reset
  always_comb begin
    if (raddr0 >= START_A) begin
      off0 = raddr0 - START_A;
    end else begin
      off0 = raddr0 + WRAP_A;
    end
    if (raddr1 >= START_A) begin
      off1 = raddr1 - START_A;
    end else begin
      off1 = raddr1 + WRAP_A;
    end
    ctl_nxt.fwd0   = (raddr0 == wptr_r);
    ctl_nxt.fwd1   = (raddr1 == wptr_r);
    ctl_nxt.blank0 = !(CW'(off0) < fill_r);
    ctl_nxt.blank1 = !(CW'(off1) < fill_r);
  end

  // Advance the write pointer and fill count on each item
  always_comb begin
    wptr_nxt = wptr_r;
    fill_nxt = fill_r;
    if (in_fire) begin
      if (wptr_r == LAST) begin
        wptr_nxt = '0;
      end else begin
        wptr_nxt = wptr_r + AW'(1);
      end
      if (fill_r != FULL) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= START_A;
      fill_r <= '0;
      v1_r   <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
      if (s1_en) begin
        v1_r <= in_fire;
      end
    end
  end

  // Hold the tap control alongside the read data
  always_ff @(posedge clk) begin
    if (s1_en) begin
      ctl_r   <= ctl_nxt;
      samp_r  <= in_sample_in;
      alpha_r <= alpha_nxt;
    end
  end

  fdli_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk    (clk),
    .we     (in_fire),
    .waddr  (wptr_r),
    .wdata  (in_sample_in),
    .re     (s1_en),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  fdli_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (v1_r),
    .s1_adv     (s2_adv),
    .ctl        (ctl_r),
    .fwd_sample (samp_r),
    .rd0        (rd0),
    .rd1        (rd1),
    .alpha      (alpha_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_bits)
  );

  assign out_sample_out = out_bits;

  // Fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond depth");

  // Pointer and fill count move only with an item
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(wptr_r) && $stable(fill_r))
    else $error("write pointer moved without an item");

  // A stalled stage-one item keeps its control and sample
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !s2_adv |=> v1_r && $stable(ctl_r) && $stable(samp_r))
    else $error("stage one changed while stalled");

  // Zero delay reads back the sample being written
  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ipart == '0 && frac == '0 |=> ctl_r.fwd0)
    else $error("zero delay did not forward the new sample");

endmodule
